[src/modexp_pkg.sv]
package modexp_pkg;

    localparam int OPW   = 32;
    localparam int CNT_W = $clog2(OPW);

    // Control into the shared modular multiplier
    typedef struct packed {
        logic start;
    } mm_req_t;

    // Status back from the shared modular multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } mm_stat_t;

    // (a + b) mod m, valid for a, b < m; one add, one subtract, one compare
    function automatic logic [OPW-1:0] add_mod(
        input logic [OPW-1:0] a,
        input logic [OPW-1:0] b,
        input logic [OPW-1:0] m
    );
        logic [OPW:0] sum;
        logic [OPW:0] dif;
        sum = {1'b0, a} + {1'b0, b};
        dif = sum - {1'b0, m};
        if (sum >= {1'b0, m}) begin
            return dif[OPW-1:0];
        end
        return sum[OPW-1:0];
    endfunction

endpackage

[src/modular_exponentiation_core.sv]
// Modular exponentiation core: power_result = base_value ^ exponent mod modulus.
// Input request on the s_ channel: s_tdata packs base_value, exponent and
// modulus. A request is taken when s_tvalid and s_tready are both high.
// The result leaves on the m_ channel as a single 32-bit word.
// Work: the base is reduced once, then right-to-left square-and-multiply
// runs over the exponent bits. Every modular product goes through one
// shared shift-and-add multiplier, one multiplier bit per cycle; each
// product runs as launch, OPW steps, then product handoff.
// Exponent zero (result 1) or modulus zero (result 0) skips the multiplier
// and goes straight to the finish state.
// Only one request is in work at a time; s_tready is high in idle only.
// The result sits in an output register, so a new request may be taken
// while the previous result still waits for m_tready. If the receiver
// stalls longer, a finished result holds in the core until the output
// register frees up.
// Reset (aresetn low, synchronous) returns to idle and drops m_tvalid.
module modular_exponentiation_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] base_value, [63:32] exponent, [95:64] modulus
    input  logic [3*modexp_pkg::OPW-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] power_result
    output logic [modexp_pkg::OPW-1:0]      m_tdata
);
    import modexp_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;  // base mod m
    localparam logic [2:0] ST_STEP   = 3'd2;  // pick next operation
    localparam logic [2:0] ST_MULR   = 3'd3;  // r = r * b mod m
    localparam logic [2:0] ST_MULB   = 3'd4;  // b = b * b mod m
    localparam logic [2:0] ST_FIN    = 3'd5;  // hand result to output reg

    logic [2:0]     state_reg, state_next;
    logic [OPW-1:0] r_reg, r_next;
    logic [OPW-1:0] b_reg, b_next;
    logic [OPW-1:0] e_reg, e_next;
    logic [OPW-1:0] m_reg, m_next;
    logic           start_reg, start_next;
    logic           out_valid_reg, out_valid_next;
    logic [OPW-1:0] out_data_reg, out_data_next;

    logic [OPW-1:0] in_base, in_exp, in_mod;
    logic [OPW-1:0] mm_a;
    logic [OPW-1:0] mm_mult;
    logic [OPW-1:0] mm_prod;
    mm_req_t        mm_req;
    mm_stat_t       mm_stat;

    assign in_base = s_tdata[OPW-1:0];
    assign in_exp  = s_tdata[2*OPW-1:OPW];
    assign in_mod  = s_tdata[3*OPW-1:2*OPW];

    assign s_tready = (state_reg == ST_IDLE);

    // Operand routing for the shared multiplier; held stable while it runs
    always_comb begin
        mm_a    = r_reg;
        mm_mult = b_reg;
        if (state_reg == ST_MULB) begin
            mm_a = b_reg;
        end
    end

    assign mm_req.start = start_reg;

    modexp_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mm_req),
        .op_a    (mm_a),
        .op_mult (mm_mult),
        .op_mod  (m_reg),
        .stat    (mm_stat),
        .product (mm_prod)
    );

    always_comb begin
        state_next     = state_reg;
        r_next         = r_reg;
        b_next         = b_reg;
        e_next         = e_reg;
        m_next         = m_reg;
        start_next     = 1'b0;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    b_next = in_base;
                    e_next = in_exp;
                    m_next = in_mod;
                    if (in_exp == '0) begin
                        r_next     = OPW'(1);
                        state_next = ST_FIN;
                    end else if (in_mod == '0) begin
                        r_next     = '0;
                        state_next = ST_FIN;
                    end else begin
                        // r starts at 1 mod m; reduction runs as (1 mod m) * base
                        r_next     = (in_mod == OPW'(1)) ? '0 : OPW'(1);
                        start_next = 1'b1;
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                if (mm_stat.done) begin
                    b_next     = mm_prod;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (e_reg == '0) begin
                    state_next = ST_FIN;
                end else if (e_reg[0]) begin
                    start_next = 1'b1;
                    state_next = ST_MULR;
                end else begin
                    start_next = 1'b1;
                    state_next = ST_MULB;
                end
            end
            ST_MULR: begin
                if (mm_stat.done) begin
                    r_next = mm_prod;
                    e_next = {e_reg[OPW-1:1], 1'b0};
                    // last set bit: the trailing square is not needed
                    if (e_reg[OPW-1:1] == '0) begin
                        state_next = ST_FIN;
                    end else begin
                        start_next = 1'b1;
                        state_next = ST_MULB;
                    end
                end
            end
            ST_MULB: begin
                if (mm_stat.done) begin
                    b_next     = mm_prod;
                    e_next     = {1'b0, e_reg[OPW-1:1]};
                    state_next = ST_STEP;
                end
            end
            ST_FIN: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = r_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
        r_reg        <= r_next;
        b_reg        <= b_next;
        e_reg        <= e_next;
        m_reg        <= m_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A new product is never launched on top of one in flight
    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |-> !mm_stat.busy)
        else $error("multiplier launched while busy");

    // Multiplier completions only land in states that consume them
    a_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mm_stat.done |-> (state_reg == ST_REDUCE || state_reg == ST_MULR ||
                          state_reg == ST_MULB))
        else $error("multiplier done outside a multiply state");

    // Exponent zero goes straight to finish with result one
    a_exp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && in_exp == '0) |=>
            (state_reg == ST_FIN && r_reg == OPW'(1)))
        else $error("exponent zero not short-cut to one");

    // Output register is never overwritten while a result is pending
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> out_valid_reg && $stable(out_data_reg))
        else $error("pending result lost");

endmodule

[src/modexp_mulmod.sv]
module modexp_mulmod (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  modexp_pkg::mm_req_t           req,
    input  logic [modexp_pkg::OPW-1:0]    op_a,
    input  logic [modexp_pkg::OPW-1:0]    op_mult,
    input  logic [modexp_pkg::OPW-1:0]    op_mod,
    output modexp_pkg::mm_stat_t          stat,
    output logic [modexp_pkg::OPW-1:0]    product
);
    import modexp_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [OPW-1:0]   acc_reg, acc_next;
    logic [OPW-1:0]   mult_reg, mult_next;
    logic [OPW-1:0]   dbl;
    logic [OPW-1:0]   step;

    // One multiplier bit per cycle, MSB first: acc = 2*acc (+ a) mod m
    assign dbl  = add_mod(acc_reg, acc_reg, op_mod);
    assign step = mult_reg[OPW-1] ? add_mod(dbl, op_a, op_mod) : dbl;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        mult_next = mult_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            mult_next = op_mult;
        end else if (busy_reg) begin
            acc_next  = step;
            mult_next = {mult_reg[OPW-2:0], 1'b0};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(OPW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        acc_reg  <= acc_next;
        mult_reg <= mult_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = acc_reg;

endmodule
